FILE: rtl/ils_pkg.sv
// ils_pkg: shared constants, codes, cell control type and read tree sizing
// for the indexed list store. No dependencies.
package ils_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ACT_W        = 3;
  localparam int unsigned POS_W        = 11;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned ST_W         = 2;
  localparam int unsigned CAPACITY_DEF = 1024;
  localparam int unsigned CAPACITY_MAX = 65536;
  localparam int unsigned IDX_W        = $clog2(CAPACITY_MAX);
  localparam int unsigned TREE_FANIN   = 32;

  localparam logic [ACT_W-1:0] ACT_GET    = 3'd0;
  localparam logic [ACT_W-1:0] ACT_HEAD   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_TAIL   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_DELETE = 3'd4;

  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL
  } cell_op_e;

  typedef struct packed {
    cell_op_e                  op;
    logic [IDX_W-1:0]          pos;
    logic signed [DATA_W-1:0]  value;
  } cell_ctl_t;

  // node count of read tree level l (level 0 = leaves)
  function automatic int level_size(int n, int l);
    int s;
    s = n;
    for (int k = 0; k < l; k++) begin
      s = (s + TREE_FANIN - 1) / TREE_FANIN;
    end
    return s;
  endfunction

  function automatic int tree_levels(int n);
    int s;
    int l;
    s = n;
    l = 0;
    for (int k = 0; k < 32; k++) begin
      if (s > 1) begin
        s = (s + TREE_FANIN - 1) / TREE_FANIN;
        l++;
      end
    end
    return l;
  endfunction

  // start of level l in a flat array holding all levels
  function automatic int level_off(int n, int l);
    int o;
    o = 0;
    for (int k = 0; k < l; k++) begin
      o += level_size(n, k);
    end
    return o;
  endfunction

endpackage

FILE: rtl/ils_cell.sv
// ils_cell: one list slot; holds a word, shifts from its left or right
// neighbor on insert or delete, and drives its word onto the read tree when selected.
// Depends on ils_pkg.
module ils_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                              clk_i,
  input  ils_pkg::cell_ctl_t                ctl_i,
  input  logic [ils_pkg::POS_W-1:0]         rd_pos_i,
  input  logic signed [ils_pkg::DATA_W-1:0] left_i,
  input  logic signed [ils_pkg::DATA_W-1:0] right_i,
  output logic signed [ils_pkg::DATA_W-1:0] data_o,
  output logic signed [ils_pkg::DATA_W-1:0] rd_o
);

  localparam int unsigned IW = ils_pkg::IDX_W;
  localparam logic [IW-1:0] IdxC = IW'(IDX);

  logic signed [ils_pkg::DATA_W-1:0] data_q;
  logic signed [ils_pkg::DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    case (ctl_i.op)
      ils_pkg::CELL_HOLD: data_d = data_q;
      ils_pkg::CELL_INS: begin
        if (IdxC > ctl_i.pos) begin
          data_d = left_i;
        end else if (IdxC == ctl_i.pos) begin
          data_d = ctl_i.value;
        end
      end
      ils_pkg::CELL_DEL: begin
        if (IdxC >= ctl_i.pos) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign rd_o   = (IW'(rd_pos_i) == IdxC) ? data_q : '0;

endmodule

FILE: rtl/ils_or_tree.sv
// ils_or_tree: registered OR-reduction tree that collects the one selected
// cell word; each level is registered. Depends on ils_pkg.
module ils_or_tree #(
  parameter int unsigned N = ils_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic signed [ils_pkg::DATA_W-1:0] leaf_i [N],
  output logic signed [ils_pkg::DATA_W-1:0] top_o
);

  localparam int Fanin  = ils_pkg::TREE_FANIN;
  localparam int Levels = ils_pkg::tree_levels(N);
  localparam int Total  = ils_pkg::level_off(N, Levels + 1);
  localparam int RegN   = Total - N;

  logic signed [ils_pkg::DATA_W-1:0] all_w  [Total];
  logic signed [ils_pkg::DATA_W-1:0] node_q [RegN];

  for (genvar i = 0; i < N; i++) begin : g_leaf
    assign all_w[i] = leaf_i[i];
  end

  for (genvar i = 0; i < RegN; i++) begin : g_reg
    assign all_w[N + i] = node_q[i];
  end

  for (genvar l = 1; l <= Levels; l++) begin : g_lvl
    localparam int Sz      = ils_pkg::level_size(N, l);
    localparam int PrevSz  = ils_pkg::level_size(N, l - 1);
    localparam int Off     = ils_pkg::level_off(N, l);
    localparam int PrevOff = ils_pkg::level_off(N, l - 1);
    for (genvar j = 0; j < Sz; j++) begin : g_node
      logic signed [ils_pkg::DATA_W-1:0] acc;
      always_comb begin
        acc = '0;
        for (int k = 0; k < Fanin; k++) begin
          if (j * Fanin + k < PrevSz) begin
            acc = acc | all_w[PrevOff + j * Fanin + k];
          end
        end
      end
      always_ff @(posedge clk_i) begin
        node_q[Off - N + j] <= acc;
      end
    end
  end

  assign top_o = all_w[Total - 1];

endmodule

FILE: rtl/indexed_list_store.sv
// indexed_list_store: ordered list of signed words kept in a chain of cells
// that shift together; insert, append, delete and get by position.
// Insert, append and delete register their result word in the cycle after
// acceptance; a get reads it through the registered read tree, which has
// L = ceil(log32(CAPACITY)) levels (2 at 1024). Throughput: one non-get word
// per cycle while the output is taken; a get holds off the input until its
// word is registered. Reset empties the list (count to zero), not the cells.
module indexed_list_store #(
  parameter int unsigned CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [ils_pkg::ACT_W-1:0]         action_i,
  input  logic [ils_pkg::POS_W-1:0]         position_i,
  input  logic signed [ils_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [ils_pkg::DATA_W-1:0] read_value_o,
  output logic [ils_pkg::ST_W-1:0]          status_o,
  output logic [ils_pkg::LEN_W-1:0]         length_o
);

  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned CW     = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
  localparam int unsigned Levels = ils_pkg::tree_levels(CAPACITY);
  localparam int unsigned RdW    = $clog2(Levels + 1);
  localparam logic [RdW-1:0]   RdLast = RdW'(Levels);
  localparam logic [CNT_W-1:0] CapC   = CNT_W'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  state_e                            state_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic [CNT_W-1:0]                  cnt_d;
  logic [RdW-1:0]                    rd_cnt_q;
  logic [ils_pkg::POS_W-1:0]         pos_q;
  logic                              get_ok_q;
  logic                              out_valid_q;
  logic signed [ils_pkg::DATA_W-1:0] read_value_q;
  logic [ils_pkg::ST_W-1:0]          status_q;
  logic [ils_pkg::LEN_W-1:0]         length_q;

  ils_pkg::cell_ctl_t                ctl;
  logic [ils_pkg::ST_W-1:0]          st;
  logic                              is_get;
  logic                              accept;
  logic                              full;
  logic [CW-1:0]                     pos_x;
  logic [CW-1:0]                     cnt_x;
  logic signed [ils_pkg::DATA_W-1:0] tree_top;

  logic signed [ils_pkg::DATA_W-1:0] data_w [CAPACITY];
  logic signed [ils_pkg::DATA_W-1:0] rd_w   [CAPACITY];

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign pos_x      = CW'(position_i);
  assign cnt_x      = CW'(cnt_q);
  assign full       = (cnt_q == CapC);

  always_comb begin
    ctl.op    = ils_pkg::CELL_HOLD;
    ctl.pos   = '0;
    ctl.value = value_i;
    cnt_d     = cnt_q;
    st        = ils_pkg::ST_DONE;
    is_get    = 1'b0;
    if (accept) begin
      case (action_i)
        ils_pkg::ACT_GET: begin
          is_get = 1'b1;
          st     = (pos_x < cnt_x) ? ils_pkg::ST_DONE : ils_pkg::ST_RANGE;
        end
        ils_pkg::ACT_HEAD, ils_pkg::ACT_TAIL: begin
          if (full) begin
            st = ils_pkg::ST_FULL;
          end else begin
            ctl.op  = ils_pkg::CELL_INS;
            ctl.pos = (action_i == ils_pkg::ACT_HEAD) ? '0 : ils_pkg::IDX_W'(cnt_q);
            cnt_d   = cnt_q + 1'b1;
          end
        end
        ils_pkg::ACT_INSERT: begin
          if (pos_x > cnt_x) begin
            st = ils_pkg::ST_RANGE;
          end else if (full) begin
            st = ils_pkg::ST_FULL;
          end else begin
            ctl.op  = ils_pkg::CELL_INS;
            ctl.pos = ils_pkg::IDX_W'(position_i);
            cnt_d   = cnt_q + 1'b1;
          end
        end
        ils_pkg::ACT_DELETE: begin
          if (pos_x >= cnt_x) begin
            st = ils_pkg::ST_RANGE;
          end else begin
            ctl.op  = ils_pkg::CELL_DEL;
            ctl.pos = ils_pkg::IDX_W'(position_i);
            cnt_d   = cnt_q - 1'b1;
          end
        end
        default: st = ils_pkg::ST_DONE;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [ils_pkg::DATA_W-1:0] left_w;
    logic signed [ils_pkg::DATA_W-1:0] right_w;
    if (i == 0) begin : g_first
      assign left_w = data_w[i];
    end else begin : g_mid_l
      assign left_w = data_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_w = data_w[i];
    end else begin : g_mid_r
      assign right_w = data_w[i+1];
    end
    ils_cell #(
      .IDX (i)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .rd_pos_i (pos_q),
      .left_i   (left_w),
      .right_i  (right_w),
      .data_o   (data_w[i]),
      .rd_o     (rd_w[i])
    );
  end

  ils_or_tree #(
    .N (CAPACITY)
  ) u_tree (
    .clk_i  (clk_i),
    .leaf_i (rd_w),
    .top_o  (tree_top)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_q        <= '0;
      rd_cnt_q     <= '0;
      pos_q        <= '0;
      get_ok_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      read_value_q <= '0;
      status_q     <= ils_pkg::ST_DONE;
      length_q     <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (out_valid_q && out_ready_i && !(accept && !is_get)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            status_q <= st;
            if (is_get) begin
              state_q  <= S_READ;
              pos_q    <= position_i;
              get_ok_q <= (st == ils_pkg::ST_DONE);
              rd_cnt_q <= '0;
            end else begin
              out_valid_q  <= 1'b1;
              read_value_q <= '0;
              length_q     <= ils_pkg::LEN_W'(cnt_d);
            end
          end
        end
        S_READ: begin
          if (rd_cnt_q == RdLast) begin
            out_valid_q  <= 1'b1;
            read_value_q <= get_ok_q ? tree_top : '1;
            length_q     <= ils_pkg::LEN_W'(cnt_q);
            state_q      <= S_IDLE;
          end else begin
            rd_cnt_q <= rd_cnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;
  assign length_o     = length_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CapC)
    else $error("element count above capacity");

  a_cnt_hold_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> $stable(cnt_q))
    else $error("element count changed during a get");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(accept) || $past(state_q == S_READ)))
    else $error("result word without a command");

  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q == ils_pkg::ST_FULL) |-> length_q == ils_pkg::LEN_W'(CAPACITY))
    else $error("full status with list not full");

  a_get_range_val: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && $past(state_q == S_READ) && status_q == ils_pkg::ST_RANGE)
      |-> read_value_q == '1)
    else $error("out of range get without minus one");

endmodule
